### rtl/core/text_mode_console_writer_defines.svh
// assertion helpers shared by the console writer modules
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define TMCW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TMCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TMCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tmcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_STOP    = 4;
  localparam int CELL_COUNT  = ROWS * COLUMNS;
  localparam int QUEUE_DEPTH = 2;

  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int CELL_AW = $clog2(CELL_COUNT + 1);
  localparam int MEM_AW  = $clog2(CELL_COUNT);
  localparam int TAB_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic        FUNC_PUT     = 1'b0;
  localparam logic        FUNC_READ    = 1'b1;
  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_TAB     = 8'd9;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  ATTR_RESET   = 8'h07;

  typedef struct packed {
    logic               func;
    logic [7:0]         char_code;
    logic [CELL_AW-1:0] read_address;
  } tmcw_in_t;

  typedef struct packed {
    logic [CELL_AW-1:0] cursor_address;
    logic [15:0]        read_data;
    logic               scrolled;
  } tmcw_out_t;

  typedef enum logic [1:0] {
    OP_READ,
    OP_NEWLINE,
    OP_TAB,
    OP_GLYPH
  } tmcw_op_t;

  // classified command handed from the front to the back
  typedef struct packed {
    tmcw_op_t           op;
    logic [7:0]         glyph;
    logic [CELL_AW-1:0] addr;
    logic               in_range;
  } tmcw_cmd_t;

endpackage

`default_nettype wire

### rtl/core/tmcw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tmcw_front import tmcw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      clearing,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tmcw_in_t  in_data,
  output logic           push_valid,
  input  wire logic      push_ready,
  output tmcw_cmd_t      push_data
);

  logic      hold_valid_r, hold_valid_nxt;
  tmcw_cmd_t hold_cmd_r, hold_cmd_nxt;
  tmcw_cmd_t cls_cmd;

  // decode the transaction into an operation
  always_comb begin
    cls_cmd.glyph    = in_data.char_code;
    cls_cmd.addr     = in_data.read_address;
    cls_cmd.in_range = (in_data.read_address < CELL_AW'(CELL_COUNT));
    if (in_data.func == FUNC_READ) begin
      cls_cmd.op = OP_READ;
    end else if (in_data.char_code == CHAR_NEWLINE) begin
      cls_cmd.op = OP_NEWLINE;
    end else if (in_data.char_code == CHAR_TAB) begin
      cls_cmd.op = OP_TAB;
    end else begin
      cls_cmd.op = OP_GLYPH;
    end
  end

  assign in_ready   = !clearing && (!hold_valid_r || push_ready);
  assign push_valid = hold_valid_r;
  assign push_data  = hold_cmd_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
      hold_cmd_nxt   = cls_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_cmd_r <= hold_cmd_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/tmcw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "text_mode_console_writer_defines.svh"

module tmcw_queue import tmcw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire tmcw_cmd_t push_data,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output tmcw_cmd_t      pop_data
);

  tmcw_cmd_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `TMCW_ASSERT_ALWAYS(a_queue_count, count_r <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue overfilled")

endmodule

`default_nettype wire

### rtl/core/tmcw_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "text_mode_console_writer_defines.svh"

module tmcw_back import tmcw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [7:0] attr,
  output logic           clearing,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire tmcw_cmd_t cmd_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output tmcw_out_t      out_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCROLL,
    S_EXEC,
    S_RDWAIT,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [TAB_W-1:0]   phase_r, phase_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CELL_AW-1:0] row_off_r, row_off_nxt;
  logic [MEM_AW-1:0]  phys_row_r, phys_row_nxt;
  logic [MEM_AW-1:0]  base_r, base_nxt;
  logic [MEM_AW-1:0]  sweep_r, sweep_nxt;
  logic [COL_W-1:0]   cnt_r, cnt_nxt;
  tmcw_cmd_t          cmd_r, cmd_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic               out_valid_r, out_valid_nxt;
  tmcw_out_t          out_data_r, out_data_nxt;

  logic [15:0]        cells [CELL_COUNT];
  logic [15:0]        rdata_r;
  logic               mem_we, mem_re;
  logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]        mem_wdata;

  logic [COL_W:0]     tab_sum;
  logic [CELL_AW:0]   glyph_sum;

  // sum of two cell indexes below the cell count, folded back into range
  function automatic logic [MEM_AW-1:0] wrap_cell(input logic [CELL_AW:0] s);
    logic [CELL_AW:0] lim;
    lim = (CELL_AW + 1)'(CELL_COUNT);
    wrap_cell = (s >= lim) ? MEM_AW'(s - lim) : MEM_AW'(s);
  endfunction

  assign clearing  = (state_r == S_CLEAR);
  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tab_sum   = (COL_W + 1)'(col_r) + (COL_W + 1)'(TAB_STOP) - (COL_W + 1)'(phase_r);
  assign glyph_sum = (CELL_AW + 1)'(phys_row_r) + (CELL_AW + 1)'(col_r);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    phase_nxt     = phase_r;
    row_nxt       = row_r;
    row_off_nxt   = row_off_r;
    phys_row_nxt  = phys_row_r;
    base_nxt      = base_r;
    sweep_nxt     = sweep_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    scrolled_nxt  = scrolled_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = sweep_r;
    mem_wdata     = BLANK_CELL;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == MEM_AW'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt      = cmd_data;
          scrolled_nxt = 1'b0;
          if (cmd_data.op == OP_READ) begin
            if (cmd_data.in_range) begin
              mem_re    = 1'b1;
              mem_raddr = wrap_cell((CELL_AW + 1)'(cmd_data.addr) + (CELL_AW + 1)'(base_r));
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (row_r == ROW_W'(ROWS)) begin
            // recycle the top physical row as the new bottom row
            row_nxt      = ROW_W'(ROWS - 1);
            row_off_nxt  = row_off_r - CELL_AW'(COLUMNS);
            sweep_nxt    = base_r;
            base_nxt     = wrap_cell((CELL_AW + 1)'(base_r) + (CELL_AW + 1)'(COLUMNS));
            cnt_nxt      = '0;
            scrolled_nxt = 1'b1;
            state_nxt    = S_SCROLL;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == COL_W'(COLUMNS - 1)) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (cmd_r.op == OP_GLYPH) begin
          mem_we    = 1'b1;
          mem_waddr = MEM_AW'(glyph_sum);
          mem_wdata = {attr, cmd_r.glyph};
        end
        if ((cmd_r.op == OP_NEWLINE)
            || (cmd_r.op == OP_TAB && tab_sum >= (COL_W + 1)'(COLUMNS))
            || (cmd_r.op == OP_GLYPH && col_r == COL_W'(COLUMNS - 1))) begin
          col_nxt      = '0;
          phase_nxt    = '0;
          row_nxt      = row_r + 1'b1;
          row_off_nxt  = row_off_r + CELL_AW'(COLUMNS);
          phys_row_nxt = wrap_cell((CELL_AW + 1)'(phys_row_r) + (CELL_AW + 1)'(COLUMNS));
        end else if (cmd_r.op == OP_TAB) begin
          col_nxt   = COL_W'(tab_sum);
          phase_nxt = '0;
        end else begin
          col_nxt   = col_r + 1'b1;
          phase_nxt = (phase_r == TAB_W'(TAB_STOP - 1)) ? '0 : phase_r + 1'b1;
        end
      end
      S_RDWAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.cursor_address = row_off_r + CELL_AW'(col_r);
          out_data_nxt.read_data      = (cmd_r.op == OP_READ && cmd_r.in_range) ? rdata_r
                                                                                : 16'h0000;
          out_data_nxt.scrolled       = scrolled_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      col_r       <= '0;
      phase_r     <= '0;
      row_r       <= '0;
      row_off_r   <= '0;
      phys_row_r  <= '0;
      base_r      <= '0;
      sweep_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      phase_r     <= phase_nxt;
      row_r       <= row_nxt;
      row_off_r   <= row_off_nxt;
      phys_row_r  <= phys_row_nxt;
      base_r      <= base_nxt;
      sweep_r     <= sweep_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    scrolled_r <= scrolled_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= cells[mem_raddr];
    end
  end

  `TMCW_ASSERT_ALWAYS(a_col_range, col_r < COL_W'(COLUMNS), "cursor column out of range")
  `TMCW_ASSERT_IMPL(a_pending_col, row_r == ROW_W'(ROWS), col_r == '0,
                    "pending scroll off column 0")
  `TMCW_ASSERT_NEXT(a_scroll_row,
                    state_r == S_IDLE && cmd_valid && cmd_data.op != OP_READ
                      && row_r == ROW_W'(ROWS),
                    row_r == ROW_W'(ROWS - 1) && state_r == S_SCROLL,
                    "scroll did not step row back")

endmodule

`default_nettype wire

### rtl/core/text_mode_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-cell console over a ROWS x COLUMNS screen store of 16-bit cells
// (attribute byte high, glyph byte low). After reset the block blanks every
// cell of the store to 0x0720 and holds in_ready low meanwhile; cfg writes
// are taken at any time. A put or read transaction then passes through the
// executing back end in steps (dispatch, execute or memory read, result
// load, held while the output register is full); a read outside the store
// skips the memory read. The back end handles one transaction at a time and
// the read of the screen memory is registered. A put that finds a scroll
// pending first blanks the recycled bottom row through the memory write port;
// rows are not moved, a circular row base tracks the top line instead. Input
// transactions are classified and queued ahead of the back end, and a finished
// result waits in the output register, so a stall on one side stops the other
// only once the buffers between them have filled.
module text_mode_console_writer import tmcw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input transactions
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tmcw_in_t   in_data,
  // result transactions
  output logic            out_valid,
  input  wire logic       out_ready,
  output tmcw_out_t       out_data,
  // text attribute register
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0] attr_r, attr_nxt;
  logic       clearing;
  logic       push_valid, push_ready;
  tmcw_cmd_t  push_data;
  logic       pop_valid, pop_ready;
  tmcw_cmd_t  pop_data;

  // attribute placed in the high byte of every printed cell
  assign attr_nxt = cfg_we ? cfg_wdata : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // front end: accept and classify
  tmcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (clearing),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // short command queue between the two halves
  tmcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back end: cursor state, screen memory, result register
  tmcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .clearing  (clearing),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
